[rtl/lfmc_pkg.sv]
// Shared types, constants and microcode program of the line follower motor controller.
package lfmc_pkg;

  // Datapath widths
  localparam int DIV_W      = 12;  // accumulator and serial divider dividend / quotient width
  localparam int LVL_W      = 8;   // sensor level width
  localparam int DUTY_W     = 4;   // PWM duty and counter width
  localparam int PC_W       = 4;   // microcode step counter width
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [1:0] {
    CMD_RUN        = 2'd0,
    CMD_LEFT_SPIN  = 2'd1,
    CMD_RIGHT_SPIN = 2'd2,
    CMD_BRAKE      = 2'd3
  } motor_cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SPIN_DIR        = 3'd0,
    CFG_MAX_SPEED       = 3'd1,
    CFG_BLACK_THR       = 3'd2,
    CFG_PWM_PERIOD      = 3'd3,
    CFG_LEFT_SPIN_DUTY  = 3'd4,
    CFG_RIGHT_SPIN_DUTY = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic              spin_dir;
    logic [DUTY_W-1:0] max_speed;
    logic [LVL_W-1:0]  black_thr;
    logic [DUTY_W-1:0] pwm_period;
    logic [DUTY_W-1:0] left_spin_duty;
    logic [DUTY_W-1:0] right_spin_duty;
  } cfg_t;

  // Register values after reset
  localparam logic              RST_SPIN_DIR        = 1'b0;
  localparam logic [DUTY_W-1:0] RST_MAX_SPEED       = 4'd8;
  localparam logic [LVL_W-1:0]  RST_BLACK_THR       = 8'd150;
  localparam logic [DUTY_W-1:0] RST_PWM_PERIOD      = 4'd10;
  localparam logic [DUTY_W-1:0] RST_LEFT_SPIN_DUTY  = 4'd5;
  localparam logic [DUTY_W-1:0] RST_RIGHT_SPIN_DUTY = 4'd6;

  // Datapath operations, one per microcode step
  typedef enum logic [3:0] {
    U_IDLE,
    U_PWM,
    U_AVG_CLR,
    U_RD,
    U_ACC,
    U_DIV_STEP,
    U_AVG_L,
    U_AVG_R,
    U_DECIDE,
    U_DUTY,
    U_FINISH,
    U_SAMPLE
  } uop_e;

  // Sequencing conditions
  typedef enum logic [2:0] {
    C_NEXT,
    C_GOTO,
    C_IF_SAMPLE,
    C_IF_NOT_CTL,
    C_IF_MORE,
    C_IF_DIV_BUSY,
    C_IF_NO_DIV,
    C_WAIT_OUT
  } cond_e;

  typedef logic [PC_W-1:0] upc_t;

  typedef struct packed {
    uop_e  uop;
    cond_e cond;
    upc_t  target;
  } uword_t;

  typedef struct packed {
    logic ctl_due;   // this tick runs the control step
    logic k_more;    // more ring entries to add
    logic div_busy;  // divider has bits left after this step
    logic no_div;    // both black, or both levels zero
  } dp_status_t;

  typedef struct packed {
    motor_cmd_e       cmd;
    logic             left_drive;
    logic             right_drive;
    logic             sample_request;
    logic [LVL_W-1:0] left_level;
    logic [LVL_W-1:0] right_level;
  } result_t;

  // Program addresses
  localparam upc_t A_IDLE    = 4'd0;
  localparam upc_t A_PWM     = 4'd1;
  localparam upc_t A_AVG_CLR = 4'd2;
  localparam upc_t A_RD      = 4'd3;
  localparam upc_t A_ACC     = 4'd4;
  localparam upc_t A_AVG_L   = 4'd5;
  localparam upc_t A_AVG_R   = 4'd6;
  localparam upc_t A_DECIDE  = 4'd7;
  localparam upc_t A_DIV_D   = 4'd8;
  localparam upc_t A_DUTY    = 4'd9;
  localparam upc_t A_FINISH  = 4'd10;
  localparam upc_t A_SAMPLE  = 4'd11;

  // Control store
  function automatic uword_t ucode_rom(upc_t pc);
    uword_t w;
    w = '{uop: U_IDLE, cond: C_IF_SAMPLE, target: A_SAMPLE};
    unique case (pc)
      A_IDLE:    w = '{uop: U_IDLE,     cond: C_IF_SAMPLE,   target: A_SAMPLE};
      A_PWM:     w = '{uop: U_PWM,      cond: C_IF_NOT_CTL,  target: A_FINISH};
      A_AVG_CLR: w = '{uop: U_AVG_CLR,  cond: C_NEXT,        target: A_IDLE};
      A_RD:      w = '{uop: U_RD,       cond: C_NEXT,        target: A_IDLE};
      A_ACC:     w = '{uop: U_ACC,      cond: C_IF_MORE,     target: A_RD};
      A_AVG_L:   w = '{uop: U_AVG_L,    cond: C_NEXT,        target: A_IDLE};
      A_AVG_R:   w = '{uop: U_AVG_R,    cond: C_NEXT,        target: A_IDLE};
      A_DECIDE:  w = '{uop: U_DECIDE,   cond: C_IF_NO_DIV,   target: A_FINISH};
      A_DIV_D:   w = '{uop: U_DIV_STEP, cond: C_IF_DIV_BUSY, target: A_DIV_D};
      A_DUTY:    w = '{uop: U_DUTY,     cond: C_NEXT,        target: A_IDLE};
      A_FINISH:  w = '{uop: U_FINISH,   cond: C_WAIT_OUT,    target: A_IDLE};
      A_SAMPLE:  w = '{uop: U_SAMPLE,   cond: C_GOTO,        target: A_FINISH};
      default:   w = '{uop: U_IDLE,     cond: C_IF_SAMPLE,   target: A_SAMPLE};
    endcase
    return w;
  endfunction

endpackage

[rtl/lfmc_if.sv]
// Valid/ready channel interfaces for sensor/tick items and motor results.
interface lfmc_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] left_sample;
  logic [7:0] right_sample;

  modport source (output valid, operation, left_sample, right_sample, input ready);
  modport sink   (input valid, operation, left_sample, right_sample, output ready);
endinterface

interface lfmc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] motor_command;
  logic       left_drive;
  logic       right_drive;
  logic       sample_request;
  logic [7:0] left_level;
  logic [7:0] right_level;

  modport source (output valid, motor_command, left_drive, right_drive, sample_request,
                  left_level, right_level, input ready);
  modport sink   (input valid, motor_command, left_drive, right_drive, sample_request,
                  left_level, right_level, output ready);
endinterface

[rtl/lfmc_seq.sv]
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module lfmc_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lfmc_pkg::dp_status_t status_i,
  input  logic                in_accept_i,
  input  logic                in_sample_i,
  input  logic                out_free_i,
  output lfmc_pkg::uword_t    word_o
);
  import lfmc_pkg::*;

  upc_t   pc_q, pc_d;
  uword_t word;
  upc_t   pc_inc;

  assign word   = ucode_rom(pc_q);
  assign word_o = word;
  assign pc_inc = pc_q + upc_t'(1);

  // next step selection
  always_comb begin
    pc_d = pc_inc;
    unique case (word.cond)
      C_NEXT:        pc_d = pc_inc;
      C_GOTO:        pc_d = word.target;
      C_IF_SAMPLE:   pc_d = !in_accept_i ? pc_q : (in_sample_i ? word.target : pc_inc);
      C_IF_NOT_CTL:  pc_d = status_i.ctl_due ? pc_inc : word.target;
      C_IF_MORE:     pc_d = status_i.k_more ? word.target : pc_inc;
      C_IF_DIV_BUSY: pc_d = status_i.div_busy ? word.target : pc_inc;
      C_IF_NO_DIV:   pc_d = status_i.no_div ? word.target : pc_inc;
      C_WAIT_OUT:    pc_d = out_free_i ? word.target : pc_q;
      default:       pc_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= A_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

[rtl/lfmc_dp.sv]
// Datapath: sample rings, PWM and tick counters, accumulators, serial divider, duty logic.
module lfmc_dp #(
  parameter int RING_DEPTH      = 8,
  parameter int AVERAGE_COUNT   = 3,
  parameter int SAMPLE_DIVIDER  = 5,
  parameter int CONTROL_DIVIDER = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lfmc_pkg::uop_e       uop_i,
  input  lfmc_pkg::cfg_t       cfg_i,
  input  logic                 in_accept_i,
  input  logic [7:0]           in_left_i,
  input  logic [7:0]           in_right_i,
  output lfmc_pkg::dp_status_t status_o,
  output lfmc_pkg::result_t    result_o
);
  import lfmc_pkg::*;

  localparam int PW  = $clog2(RING_DEPTH);
  localparam int KW  = $clog2(AVERAGE_COUNT + 1);
  localparam int SW  = $clog2(SAMPLE_DIVIDER + 1);
  localparam int CW  = $clog2(CONTROL_DIVIDER + 1);
  localparam int DCW = $clog2(DIV_W);
  localparam int MW  = 2 * LVL_W;

  // Mean by reciprocal: floor(x / n) = (x * ceil(2^s / n)) >> s, s = DIV_W + clog2(n)
  localparam int             AVG_SH    = DIV_W + $clog2(AVERAGE_COUNT);
  localparam int             AVG_PW    = 2 * DIV_W + 1;
  localparam logic [DIV_W:0] AVG_RECIP =
      (DIV_W + 1)'(((1 << AVG_SH) + AVERAGE_COUNT - 1) / AVERAGE_COUNT);

  // Ring memory, both sides in one word: {left, right}
  logic [MW-1:0]         mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] valid_q;
  logic [MW-1:0]         rd_q;
  logic [PW-1:0]         ptr_q, ptr_inc, rp_q;
  logic [KW-1:0]         k_q;

  // Latched input samples
  logic [LVL_W-1:0] smp_l_q, smp_r_q;

  // Counters and control state
  logic [DUTY_W-1:0] pwm_q, pwm_inc;
  logic [SW-1:0]     scnt_q, scnt_inc;
  logic [CW-1:0]     ccnt_q, ccnt_inc;
  logic              s_wrap, c_wrap;
  logic              spin_q, lgt_q, req_q;
  logic [DUTY_W-1:0] lduty_q, rduty_q;
  logic [LVL_W-1:0]  lavg_q, ravg_q;
  motor_cmd_e        cmd_q;
  logic              ldrv_q, rdrv_q;

  // Accumulators, means and divider
  logic [DIV_W-1:0]  acc_l_q, acc_r_q;
  logic [AVG_PW-1:0] prod_l, prod_r;
  logic [LVL_W-1:0]  avg_l, avg_r;
  logic [DIV_W-1:0]  dvd_q;
  logic [LVL_W-1:0]  dvs_q, rem_q, rem_d;
  logic [DCW-1:0]    dcnt_q;
  logic [LVL_W:0]    trial, diff;
  logic              ge;

  // Decision terms
  logic             black, l_gt, both_zero;
  logic [LVL_W-1:0] big, small_lvl, mid;
  logic [DIV_W-1:0] prod;

  assign ptr_inc  = (ptr_q == PW'(RING_DEPTH - 1)) ? '0 : ptr_q + PW'(1);
  assign pwm_inc  = pwm_q + DUTY_W'(1);
  assign scnt_inc = scnt_q + SW'(1);
  assign ccnt_inc = ccnt_q + CW'(1);
  assign s_wrap   = scnt_inc >= SW'(SAMPLE_DIVIDER);
  assign c_wrap   = ccnt_inc >= CW'(CONTROL_DIVIDER);

  // floor means of the accumulated samples
  assign prod_l = AVG_PW'(acc_l_q) * AVG_PW'(AVG_RECIP);
  assign prod_r = AVG_PW'(acc_r_q) * AVG_PW'(AVG_RECIP);
  assign avg_l  = prod_l[AVG_SH +: LVL_W];
  assign avg_r  = prod_r[AVG_SH +: LVL_W];

  // restoring divider, one quotient bit per step
  assign trial = {rem_q, dvd_q[DIV_W-1]};
  assign ge    = trial >= {1'b0, dvs_q};
  assign diff  = trial - {1'b0, dvs_q};
  assign rem_d = ge ? diff[LVL_W-1:0] : trial[LVL_W-1:0];

  // control decision on the averaged levels
  assign black     = (lavg_q >= cfg_i.black_thr) && (ravg_q >= cfg_i.black_thr);
  assign l_gt      = lavg_q > ravg_q;
  assign both_zero = !l_gt && (ravg_q == '0);
  assign big       = l_gt ? lavg_q : ravg_q;
  assign small_lvl = l_gt ? ravg_q : lavg_q;
  assign mid       = small_lvl + ((big - small_lvl) >> 1);
  assign prod      = DIV_W'(mid) * DIV_W'(cfg_i.max_speed);

  assign status_o.ctl_due  = c_wrap;
  assign status_o.k_more   = k_q != KW'(AVERAGE_COUNT);
  assign status_o.div_busy = dcnt_q != DCW'(DIV_W - 1);
  assign status_o.no_div   = black || both_zero;

  assign result_o.cmd            = cmd_q;
  assign result_o.left_drive     = ldrv_q;
  assign result_o.right_drive    = rdrv_q;
  assign result_o.sample_request = req_q;
  assign result_o.left_level     = lavg_q;
  assign result_o.right_level    = ravg_q;

  // ring write
  always_ff @(posedge clk_i) begin
    if (uop_i == U_SAMPLE) begin
      mem[ptr_inc] <= {smp_l_q, smp_r_q};
    end
  end

  // ring read, unwritten entries read as zero
  always_ff @(posedge clk_i) begin
    if (uop_i == U_RD) begin
      rd_q <= valid_q[rp_q] ? mem[rp_q] : '0;
    end
  end

  // input latch, accumulators and divider
  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      smp_l_q <= in_left_i;
      smp_r_q <= in_right_i;
    end
    unique case (uop_i)
      U_AVG_CLR: begin
        acc_l_q <= '0;
        acc_r_q <= '0;
      end
      U_ACC: begin
        acc_l_q <= acc_l_q + DIV_W'(rd_q[MW-1:LVL_W]);
        acc_r_q <= acc_r_q + DIV_W'(rd_q[LVL_W-1:0]);
      end
      U_DECIDE: begin
        dvd_q  <= prod;
        dvs_q  <= big;
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      U_DIV_STEP: begin
        dvd_q  <= {dvd_q[DIV_W-2:0], ge};
        rem_q  <= rem_d;
        dcnt_q <= dcnt_q + DCW'(1);
      end
      default: begin
      end
    endcase
  end

  // controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ptr_q   <= '0;
      rp_q    <= '0;
      k_q     <= '0;
      pwm_q   <= '0;
      scnt_q  <= '0;
      ccnt_q  <= '0;
      spin_q  <= 1'b0;
      lgt_q   <= 1'b0;
      req_q   <= 1'b0;
      lduty_q <= '0;
      rduty_q <= '0;
      lavg_q  <= '0;
      ravg_q  <= '0;
      cmd_q   <= CMD_RUN;
      ldrv_q  <= 1'b0;
      rdrv_q  <= 1'b0;
    end else begin
      unique case (uop_i)
        U_SAMPLE: begin
          ptr_q            <= ptr_inc;
          valid_q[ptr_inc] <= 1'b1;
          req_q            <= 1'b0;
        end
        U_PWM: begin
          if (spin_q) begin
            if (!cfg_i.spin_dir) begin
              cmd_q <= (pwm_inc <= cfg_i.left_spin_duty) ? CMD_LEFT_SPIN : CMD_BRAKE;
            end else begin
              cmd_q <= (pwm_inc <= cfg_i.right_spin_duty) ? CMD_RIGHT_SPIN : CMD_BRAKE;
            end
            ldrv_q <= 1'b0;
            rdrv_q <= 1'b0;
          end else begin
            cmd_q  <= CMD_RUN;
            ldrv_q <= pwm_inc <= lduty_q;
            rdrv_q <= pwm_inc <= rduty_q;
          end
          pwm_q  <= (pwm_inc >= cfg_i.pwm_period) ? '0 : pwm_inc;
          scnt_q <= s_wrap ? '0 : scnt_inc;
          req_q  <= s_wrap;
          ccnt_q <= c_wrap ? '0 : ccnt_inc;
        end
        U_AVG_CLR: begin
          rp_q <= ptr_q;
          k_q  <= '0;
        end
        U_RD: begin
          rp_q <= (rp_q == '0) ? PW'(RING_DEPTH - 1) : rp_q - PW'(1);
          k_q  <= k_q + KW'(1);
        end
        U_AVG_L: lavg_q <= avg_l;
        U_AVG_R: ravg_q <= avg_r;
        U_DECIDE: begin
          lgt_q <= l_gt;
          if (black) begin
            spin_q <= 1'b1;
            cmd_q  <= CMD_BRAKE;
            ldrv_q <= 1'b0;
            rdrv_q <= 1'b0;
          end else begin
            spin_q <= 1'b0;
            if (l_gt) begin
              lduty_q <= cfg_i.max_speed;
            end else if (!both_zero) begin
              rduty_q <= cfg_i.max_speed;
            end else begin
              lduty_q <= cfg_i.max_speed;
              rduty_q <= cfg_i.max_speed;
            end
          end
        end
        U_DUTY: begin
          if (lgt_q) begin
            rduty_q <= dvd_q[DUTY_W-1:0];
          end else begin
            lduty_q <= dvd_q[DUTY_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/line_follower_motor_controller.sv]
// Line follower motor controller top level: config registers, result register, sequencer.
// A sample item or a tick without control step runs SAMPLE or PWM, then FINISH loads the result.
// A control tick (every CONTROL_DIVIDER-th) runs PWM, AVG_CLR, one RD/ACC pair per averaged sample
// (single-port ring reads), AVG_L, AVG_R, DECIDE, the 12-step serial divider that scales the dimmer
// side's duty, DUTY and FINISH; the divider and DUTY are skipped when both sides are black or both levels are zero.
// Reset (async, active low) restores register defaults, clears rings, counters and duties.
module line_follower_motor_controller #(
  parameter int RING_DEPTH      = 8,
  parameter int AVERAGE_COUNT   = 3,
  parameter int SAMPLE_DIVIDER  = 5,
  parameter int CONTROL_DIVIDER = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [lfmc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lfmc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lfmc_in_if.sink                           in_if,
  lfmc_out_if.source                        out_if
);
  import lfmc_pkg::*;

  cfg_t       cfg_q;
  uword_t     word;
  dp_status_t status;
  result_t    res, res_q;
  logic       out_valid_q;
  logic       in_accept, out_free, finish;

  assign in_if.ready = word.uop == U_IDLE;
  assign in_accept   = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_q || out_if.ready;
  assign finish      = (word.uop == U_FINISH) && out_free;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.spin_dir        <= RST_SPIN_DIR;
      cfg_q.max_speed       <= RST_MAX_SPEED;
      cfg_q.black_thr       <= RST_BLACK_THR;
      cfg_q.pwm_period      <= RST_PWM_PERIOD;
      cfg_q.left_spin_duty  <= RST_LEFT_SPIN_DUTY;
      cfg_q.right_spin_duty <= RST_RIGHT_SPIN_DUTY;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SPIN_DIR:        cfg_q.spin_dir        <= cfg_data_i[0];
        CFG_MAX_SPEED:       cfg_q.max_speed       <= cfg_data_i[DUTY_W-1:0];
        CFG_BLACK_THR:       cfg_q.black_thr       <= cfg_data_i[LVL_W-1:0];
        CFG_PWM_PERIOD:      cfg_q.pwm_period      <= cfg_data_i[DUTY_W-1:0];
        CFG_LEFT_SPIN_DUTY:  cfg_q.left_spin_duty  <= cfg_data_i[DUTY_W-1:0];
        CFG_RIGHT_SPIN_DUTY: cfg_q.right_spin_duty <= cfg_data_i[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lfmc_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .status_i    (status),
    .in_accept_i (in_accept),
    .in_sample_i (in_if.operation),
    .out_free_i  (out_free),
    .word_o      (word)
  );

  lfmc_dp #(
    .RING_DEPTH      (RING_DEPTH),
    .AVERAGE_COUNT   (AVERAGE_COUNT),
    .SAMPLE_DIVIDER  (SAMPLE_DIVIDER),
    .CONTROL_DIVIDER (CONTROL_DIVIDER)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_i       (word.uop),
    .cfg_i       (cfg_q),
    .in_accept_i (in_accept),
    .in_left_i   (in_if.left_sample),
    .in_right_i  (in_if.right_sample),
    .status_o    (status),
    .result_o    (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      res_q <= res;
    end
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.motor_command  = res_q.cmd;
  assign out_if.left_drive     = res_q.left_drive;
  assign out_if.right_drive    = res_q.right_drive;
  assign out_if.sample_request = res_q.sample_request;
  assign out_if.left_level     = res_q.left_level;
  assign out_if.right_level    = res_q.right_level;

endmodule

[verif/line_follower_motor_controller_tb.sv]
// Self-checking testbench for the line follower motor controller: directed and random items.
`timescale 1ns / 100ps
module line_follower_motor_controller_tb;
  import lfmc_pkg::*;

  localparam int HIST_DEPTH      = 8;
  localparam int MEAN_TAPS       = 3;
  localparam int SAMPLE_EVERY    = 5;
  localparam int CONTROL_EVERY   = 10;
  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 110;
  localparam int SETTLE_CYCLES   = 64;
  localparam int CYCLE_LIMIT     = 800000;

  // Item operations and the register indexes the block does not map
  localparam logic                 OP_TICK     = 1'b0;
  localparam logic                 OP_SAMPLE   = 1'b1;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] UNMAPPED_HI = 3'd7;

  typedef struct packed {
    logic       op;
    logic [7:0] left_byte;
    logic [7:0] right_byte;
  } sensor_item_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  lfmc_in_if  sensor_ch ();
  lfmc_out_if motor_ch ();

  line_follower_motor_controller u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (sensor_ch),
    .out_if     (motor_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Stimulus and expectation stores
  sensor_item_t sensor_items [$];
  result_t      motor_expected [$];
  int unsigned  item_total;
  int unsigned  error_count;
  int unsigned  cycle_count;

  // Predictor state
  cfg_t        ctrl_cfg;
  logic [7:0]  left_hist [HIST_DEPTH];
  logic [7:0]  right_hist [HIST_DEPTH];
  logic [2:0]  hist_ptr;
  logic [3:0]  pwm_pos;
  int unsigned sample_ticks;
  int unsigned control_ticks;
  logic        spin_active;
  logic [3:0]  left_duty;
  logic [3:0]  right_duty;
  logic [7:0]  left_avg;
  logic [7:0]  right_avg;
  motor_cmd_e  drive_cmd;
  logic        drive_left;
  logic        drive_right;

  // Floor mean of the newest samples of one side
  function automatic logic [7:0] recent_mean(logic [7:0] hist [HIST_DEPTH]);
    int unsigned sum;
    logic [2:0]  idx;
    sum = 0;
    for (int i = 0; i < MEAN_TAPS; i++) begin
      idx = hist_ptr - 3'(i);
      sum += hist[idx];
    end
    return 8'(sum / MEAN_TAPS);
  endfunction

  // Next motor result for one accepted item; updates the predictor state
  function automatic result_t controller_step(sensor_item_t item);
    result_t     res;
    int unsigned l;
    int unsigned r;
    res.sample_request = 1'b0;
    if (item.op == OP_SAMPLE) begin
      hist_ptr = hist_ptr + 3'd1;
      left_hist[hist_ptr]  = item.left_byte;
      right_hist[hist_ptr] = item.right_byte;
    end else begin
      // PWM step with the current mode and duties
      pwm_pos = pwm_pos + 4'd1;
      if (spin_active) begin
        drive_left  = 1'b0;
        drive_right = 1'b0;
        if (!ctrl_cfg.spin_dir) begin
          drive_cmd = (pwm_pos <= ctrl_cfg.left_spin_duty) ? CMD_LEFT_SPIN : CMD_BRAKE;
        end else begin
          drive_cmd = (pwm_pos <= ctrl_cfg.right_spin_duty) ? CMD_RIGHT_SPIN : CMD_BRAKE;
        end
      end else begin
        drive_cmd   = CMD_RUN;
        drive_left  = (pwm_pos <= left_duty);
        drive_right = (pwm_pos <= right_duty);
      end
      if (pwm_pos >= ctrl_cfg.pwm_period) begin
        pwm_pos = '0;
      end

      sample_ticks++;
      if (sample_ticks >= SAMPLE_EVERY) begin
        sample_ticks = 0;
        res.sample_request = 1'b1;
      end

      // Control step: average, then spin or steer
      control_ticks++;
      if (control_ticks >= CONTROL_EVERY) begin
        control_ticks = 0;
        left_avg  = recent_mean(left_hist);
        right_avg = recent_mean(right_hist);
        l = left_avg;
        r = right_avg;
        if (l >= ctrl_cfg.black_thr && r >= ctrl_cfg.black_thr) begin
          spin_active = 1'b1;
          drive_cmd   = CMD_BRAKE;
          drive_left  = 1'b0;
          drive_right = 1'b0;
        end else begin
          spin_active = 1'b0;
          if (l > r) begin
            left_duty  = ctrl_cfg.max_speed;
            right_duty = 4'(((r + (l - r) / 2) * ctrl_cfg.max_speed) / l);
          end else if (r != 0) begin
            right_duty = ctrl_cfg.max_speed;
            left_duty  = 4'(((l + (r - l) / 2) * ctrl_cfg.max_speed) / r);
          end else begin
            // both levels zero: no division, full speed both sides
            left_duty  = ctrl_cfg.max_speed;
            right_duty = ctrl_cfg.max_speed;
          end
        end
      end
    end
    res.cmd         = drive_cmd;
    res.left_drive  = drive_left;
    res.right_drive = drive_right;
    res.left_level  = left_avg;
    res.right_level = right_avg;
    return res;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void push_item(logic op, logic [7:0] lv, logic [7:0] rv);
    sensor_items.push_back('{op: op, left_byte: lv, right_byte: rv});
    item_total++;
  endfunction

  function automatic logic [7:0] near_level(int unsigned thr);
    int v;
    v = int'(thr) + int'($urandom_range(0, 2)) - 1;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return 8'(v);
  endfunction

  // One control window: a few samples of one kind, then a run of ticks with stray samples
  task automatic add_segment();
    int unsigned kind;
    int unsigned n_samples;
    int unsigned n_ticks;
    int unsigned thr;
    logic [7:0]  lv;
    logic [7:0]  rv;
    kind      = $urandom_range(0, 9);
    thr       = ctrl_cfg.black_thr;
    n_samples = (kind == 9) ? $urandom_range(0, 2) : $urandom_range(3, 5);
    for (int i = 0; i < n_samples; i++) begin
      lv = 8'($urandom);
      rv = 8'($urandom);
      case (kind)
        0, 1: begin
          lv = 8'($urandom_range(255, thr));
          rv = 8'($urandom_range(255, thr));
        end
        2: begin
          lv = near_level(thr);
          rv = near_level(thr);
        end
        3: begin
          lv = '0;
          rv = '0;
        end
        4: rv = lv;
        5: lv = 8'($urandom_range(255, thr));
        6: rv = 8'($urandom_range(255, thr));
        default: ;
      endcase
      push_item(OP_SAMPLE, lv, rv);
    end
    n_ticks = $urandom_range(1, 12);
    for (int i = 0; i < n_ticks; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(OP_SAMPLE, 8'($urandom), 8'($urandom));
      end
      push_item(OP_TICK, 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_SPIN_DIR:        ctrl_cfg.spin_dir        = data[0];
      CFG_MAX_SPEED:       ctrl_cfg.max_speed       = data[3:0];
      CFG_BLACK_THR:       ctrl_cfg.black_thr       = data;
      CFG_PWM_PERIOD:      ctrl_cfg.pwm_period      = data[3:0];
      CFG_LEFT_SPIN_DUTY:  ctrl_cfg.left_spin_duty  = data[3:0];
      CFG_RIGHT_SPIN_DUTY: ctrl_cfg.right_spin_duty = data[3:0];
      default: ;
    endcase
  endtask

  // Writes every register; pad fills the bits above each field
  task automatic configure(logic sd, logic [3:0] ms, logic [7:0] thr, logic [3:0] per,
                           logic [3:0] lsd, logic [3:0] rsd, logic [7:0] pad);
    write_reg(CFG_SPIN_DIR, {pad[7:1], sd});
    write_reg(CFG_MAX_SPEED, {pad[7:4], ms});
    write_reg(CFG_BLACK_THR, thr);
    write_reg(CFG_PWM_PERIOD, {pad[7:4], per});
    write_reg(CFG_LEFT_SPIN_DUTY, {pad[7:4], lsd});
    write_reg(CFG_RIGHT_SPIN_DUTY, {pad[7:4], rsd});
    write_reg(UNMAPPED_LO, 8'($urandom));
    write_reg(UNMAPPED_HI, 8'($urandom));
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Block is idle once every item is taken and every result is back
  task automatic wait_drained();
    do @(negedge clk_i);
    while (sensor_items.size() != 0 || sensor_ch.valid || motor_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Input driver: bursts of items with random gaps
  sensor_item_t held_item;
  int unsigned  burst_left;
  int unsigned  gap_left;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      sensor_ch.valid <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (sensor_ch.valid && sensor_ch.ready) begin
        motor_expected.push_back(controller_step(held_item));
      end
      if (!sensor_ch.valid || sensor_ch.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          sensor_ch.valid <= 1'b0;
        end else if (sensor_items.size() != 0) begin
          held_item = sensor_items.pop_front();
          sensor_ch.valid        <= 1'b1;
          sensor_ch.operation    <= held_item.op;
          sensor_ch.left_sample  <= held_item.left_byte;
          sensor_ch.right_sample <= held_item.right_byte;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
          end
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 3))
              0:       gap_left = 0;
              3:       gap_left = $urandom_range(5, 60);
              default: gap_left = $urandom_range(1, 4);
            endcase
          end
        end else begin
          sensor_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: 32-bit ready stall pattern, reloaded once fully used
  logic [31:0] ready_pattern;
  int unsigned pattern_left;
  result_t     want_result;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      motor_ch.ready <= 1'b0;
      pattern_left = 0;
    end else begin
      if (motor_ch.valid && motor_ch.ready) begin
        if (motor_expected.size() == 0) begin
          $error("result transfer with nothing expected: motor_command %0d",
                 motor_ch.motor_command);
          error_count++;
        end else begin
          want_result = motor_expected.pop_front();
          check_field("motor_command", want_result.cmd, motor_ch.motor_command);
          check_field("left_drive", want_result.left_drive, motor_ch.left_drive);
          check_field("right_drive", want_result.right_drive, motor_ch.right_drive);
          check_field("sample_request", want_result.sample_request, motor_ch.sample_request);
          check_field("left_level", want_result.left_level, motor_ch.left_level);
          check_field("right_level", want_result.right_level, motor_ch.right_level);
        end
      end
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = '1;
          1:       ready_pattern = $urandom | $urandom;
          2:       ready_pattern = $urandom;
          default: ready_pattern = $urandom & $urandom;
        endcase
        pattern_left = 32;
      end
      motor_ch.ready <= ready_pattern[0];
      ready_pattern = {ready_pattern[0], ready_pattern[31:1]};
      pattern_left--;
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("line_follower_motor_controller_tb: FAIL");
    $finish;
  end

  // Main sequence
  initial begin
    int unsigned phase_start;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = '0;
    cfg_data_i             = '0;
    sensor_ch.valid        = 1'b0;
    sensor_ch.operation    = OP_TICK;
    sensor_ch.left_sample  = '0;
    sensor_ch.right_sample = '0;
    motor_ch.ready         = 1'b0;
    item_total             = 0;
    error_count            = 0;

    // Predictor at reset
    ctrl_cfg = '{spin_dir: RST_SPIN_DIR, max_speed: RST_MAX_SPEED, black_thr: RST_BLACK_THR,
                 pwm_period: RST_PWM_PERIOD, left_spin_duty: RST_LEFT_SPIN_DUTY,
                 right_spin_duty: RST_RIGHT_SPIN_DUTY};
    for (int i = 0; i < HIST_DEPTH; i++) begin
      left_hist[i]  = '0;
      right_hist[i] = '0;
    end
    hist_ptr      = '0;
    pwm_pos       = '0;
    sample_ticks  = 0;
    control_ticks = 0;
    spin_active   = 1'b0;
    left_duty     = '0;
    right_duty    = '0;
    left_avg      = '0;
    right_avg     = '0;
    drive_cmd     = CMD_RUN;
    drive_left    = 1'b0;
    drive_right   = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: both sides black -> brake then spin; both zero -> full speed both sides
    for (int i = 0; i < 3; i++) push_item(OP_SAMPLE, 8'hFF, 8'hFF);
    for (int i = 0; i < CONTROL_EVERY; i++) push_item(OP_TICK, 8'h00, 8'hFF);
    for (int i = 0; i < 3; i++) push_item(OP_SAMPLE, 8'h00, 8'h00);
    for (int i = 0; i < CONTROL_EVERY; i++) push_item(OP_TICK, 8'hFF, 8'h00);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: configure(1'b1, 4'd15, 8'd255, 4'd15, 4'd15, 4'd0, 8'h00);
        2: configure(1'b0, 4'd0, 8'd0, 4'd1, 4'd0, 4'd15, 8'h00);
        // zero period: the counter clears on every tick
        3: configure(1'b1, 4'd15, 8'd1, 4'd0, 4'd3, 4'd9, 8'hFF);
        default: configure(1'($urandom), 4'($urandom), 8'($urandom_range(220, 60)),
                           4'($urandom), 4'($urandom), 4'($urandom), 8'($urandom));
      endcase
      phase_start = item_total;
      while (item_total - phase_start < ITEMS_PER_PHASE) add_segment();
      wait_drained();
    end

    if (error_count == 0) begin
      $display("line_follower_motor_controller_tb: PASS");
    end else begin
      $display("line_follower_motor_controller_tb: FAIL");
    end
    $finish;
  end

endmodule
